// ===== rtl/lswc_pkg.sv =====
`timescale 1ns / 1ps

package lswc_pkg;

	localparam int COORD_BITS = 16;
	localparam int LANES      = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] mag_t;
	typedef logic        [2*COORD_BITS-1:0] prod_t;
	typedef logic signed [COORD_BITS:0]   wide_t;
	typedef logic signed [COORD_BITS+1:0] ext_t;

	// nine-way region codes
	typedef enum logic [3:0] {
		RGN_INSIDE = 4'd0,
		RGN_TOP    = 4'd1,
		RGN_LEFT   = 4'd2,
		RGN_RIGHT  = 4'd3,
		RGN_BOTTOM = 4'd4,
		RGN_TL     = 4'd5,
		RGN_TR     = 4'd6,
		RGN_BL     = 4'd7,
		RGN_BR     = 4'd8
	} region_t;

	// register indexes
	localparam logic [1:0] CFG_LEFT   = 2'd0;
	localparam logic [1:0] CFG_BOTTOM = 2'd1;
	localparam logic [1:0] CFG_RIGHT  = 2'd2;
	localparam logic [1:0] CFG_TOP    = 2'd3;

	localparam coord_t LEFT_RST   = coord_t'(-9830);
	localparam coord_t BOTTOM_RST = coord_t'(-6554);
	localparam coord_t RIGHT_RST  = coord_t'(9830);
	localparam coord_t TOP_RST    = coord_t'(6554);

	// intersection lanes
	localparam int LANE_SV = 0;
	localparam int LANE_SH = 1;
	localparam int LANE_EV = 2;
	localparam int LANE_EH = 3;

	typedef struct packed {
		coord_t left;
		coord_t bottom;
		coord_t right;
		coord_t top;
	} window_t;

	typedef struct packed {
		logic   ok;
		logic   neg;
		logic   vert;
		coord_t base;
		coord_t edge_pos;
	} lane_t;

	typedef struct packed {
		lane_t side;
		mag_t  num;
		mag_t  den;
		mag_t  dv;
	} setup_t;

	typedef struct packed {
		region_t rs;
		region_t re;
		coord_t  sx;
		coord_t  sy;
		coord_t  ex;
		coord_t  ey;
	} item_t;

	function automatic region_t region_of(coord_t x, coord_t y, window_t w);
		logic xmid, ymid;
		region_t r;
		xmid = (x >= w.left) && (x <= w.right);
		ymid = (y >= w.bottom) && (y <= w.top);
		if (xmid && ymid) r = RGN_INSIDE;
		else if (xmid && y >= w.top) r = RGN_TOP;
		else if (ymid && x <= w.left) r = RGN_LEFT;
		else if (ymid && x >= w.right) r = RGN_RIGHT;
		else if (xmid && y <= w.bottom) r = RGN_BOTTOM;
		else if (x <= w.left && y >= w.top) r = RGN_TL;
		else if (x >= w.right && y >= w.top) r = RGN_TR;
		else if (x <= w.left && y <= w.bottom) r = RGN_BL;
		else r = RGN_BR;
		return r;
	endfunction

endpackage

// ===== rtl/lswc_seg_if.sv =====
`timescale 1ns / 1ps

interface lswc_seg_if;
	import lswc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/lswc_clip_if.sv =====
`timescale 1ns / 1ps

interface lswc_clip_if;
	import lswc_pkg::*;

	logic       valid;
	logic       ready;
	logic       visible;
	coord_t     clip_start_x;
	coord_t     clip_start_y;
	coord_t     clip_end_x;
	coord_t     clip_end_y;
	logic [3:0] start_region;
	logic [3:0] end_region;

	modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, start_region, end_region, input ready);
	modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, start_region, end_region, output ready);
endinterface

// ===== rtl/lswc_div.sv =====
`timescale 1ns / 1ps

module lswc_div (
	input  logic           clk,
	input  logic           en,
	input  lswc_pkg::prod_t dividend,
	input  lswc_pkg::mag_t  divisor,
	output lswc_pkg::mag_t  quotient
);
	import lswc_pkg::*;

	// restoring division, one quotient bit per stage
	mag_t rem_sd [COORD_BITS];
	mag_t lo_sd  [COORD_BITS];
	mag_t dvs_sd [COORD_BITS];
	mag_t quo_sd [COORD_BITS];

	for (genvar i = 0; i < COORD_BITS; i++) begin : g_stage
		mag_t rem_in, lo_in, dvs_in, quo_in;
		logic [COORD_BITS:0] trial, diff;
		logic take;

		if (i == 0) begin : g_first
			assign rem_in = dividend[2*COORD_BITS-1:COORD_BITS];
			assign lo_in  = dividend[COORD_BITS-1:0];
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[i-1];
			assign lo_in  = lo_sd[i-1];
			assign dvs_in = dvs_sd[i-1];
			assign quo_in = quo_sd[i-1];
		end

		assign trial = {rem_in, lo_in[COORD_BITS-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign take  = trial >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i] <= take ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
				lo_sd[i]  <= {lo_in[COORD_BITS-2:0], 1'b0};
				dvs_sd[i] <= dvs_in;
				quo_sd[i] <= {quo_in[COORD_BITS-2:0], take};
			end
		end
	end

	assign quotient = quo_sd[COORD_BITS-1];
endmodule

// ===== rtl/line_segment_window_clip.sv =====
`timescale 1ns / 1ps

// channel  | modport | payload
// seg      | sink    | start_x, start_y, end_x, end_y
// clip     | source  | visible, clip_start/end x/y, start_region, end_region
// cfg_*    | write   | cfg_index selects left, bottom, right, top
//
// one segment per cycle while clip is not stalled; pipeline: setup, multiply, 16 divider
// stages (one quotient bit each), select and output register
// four divider lanes run in parallel, one per candidate edge crossing
// arst_n clears valid bits and loads the default window
// a stall on clip freezes every stage; seg.ready drops with it

module line_segment_window_clip (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  lswc_pkg::coord_t  cfg_data,
	lswc_seg_if.sink          seg,
	lswc_clip_if.source       clip
);
	import lswc_pkg::*;

	localparam int DIV_STAGES = COORD_BITS;

	window_t win_q;
	logic    en;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '{left: LEFT_RST, bottom: BOTTOM_RST, right: RIGHT_RST, top: TOP_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEFT:   win_q.left   <= cfg_data;
				CFG_BOTTOM: win_q.bottom <= cfg_data;
				CFG_RIGHT:  win_q.right  <= cfg_data;
				CFG_TOP:    win_q.top    <= cfg_data;
				default:    win_q.top    <= cfg_data;
			endcase
		end
	end

	function automatic setup_t lane_setup(coord_t u0, coord_t u1, coord_t v0, coord_t v1,
		coord_t e, logic used, logic vert);
		wide_t a, d, dv, dva;
		setup_t s;
		a  = wide_t'(e) - wide_t'(u0);
		d  = wide_t'(u1) - wide_t'(u0);
		dv = wide_t'(v1) - wide_t'(v0);
		if (d < 0) begin
			d = -d;
			a = -a;
		end
		dva = (dv < 0) ? -dv : dv;
		s.side.ok       = used && (d != 0) && (a >= 0) && (a <= d);
		s.side.neg      = dv < 0;
		s.side.vert     = vert;
		s.side.base     = v0;
		s.side.edge_pos = e;
		s.num = a[COORD_BITS-1:0];
		s.den = d[COORD_BITS-1:0];
		s.dv  = dva[COORD_BITS-1:0];
		return s;
	endfunction

	assign en        = !clip.valid || clip.ready;
	assign seg.ready = en;

	// stage 1: regions and edge setup
	item_t   item_c;
	setup_t  su [LANES];
	logic    s_v, s_h, e_v, e_h;
	coord_t  s_xv, s_yh, e_xv, e_yh;

	always_comb begin
		item_c.sx = seg.start_x;
		item_c.sy = seg.start_y;
		item_c.ex = seg.end_x;
		item_c.ey = seg.end_y;
		item_c.rs = region_of(seg.start_x, seg.start_y, win_q);
		item_c.re = region_of(seg.end_x, seg.end_y, win_q);
		s_v  = !(item_c.rs == RGN_INSIDE || item_c.rs == RGN_TOP || item_c.rs == RGN_BOTTOM);
		s_h  = !(item_c.rs == RGN_INSIDE || item_c.rs == RGN_LEFT || item_c.rs == RGN_RIGHT);
		e_v  = !(item_c.re == RGN_INSIDE || item_c.re == RGN_TOP || item_c.re == RGN_BOTTOM);
		e_h  = !(item_c.re == RGN_INSIDE || item_c.re == RGN_LEFT || item_c.re == RGN_RIGHT);
		s_xv = (item_c.rs == RGN_LEFT || item_c.rs == RGN_TL || item_c.rs == RGN_BL) ?
			win_q.left : win_q.right;
		s_yh = (item_c.rs == RGN_TOP || item_c.rs == RGN_TL || item_c.rs == RGN_TR) ?
			win_q.top : win_q.bottom;
		e_xv = (item_c.re == RGN_LEFT || item_c.re == RGN_TL || item_c.re == RGN_BL) ?
			win_q.left : win_q.right;
		e_yh = (item_c.re == RGN_TOP || item_c.re == RGN_TL || item_c.re == RGN_TR) ?
			win_q.top : win_q.bottom;
		su[LANE_SV] = lane_setup(item_c.sx, item_c.ex, item_c.sy, item_c.ey, s_xv, s_v, 1'b1);
		su[LANE_SH] = lane_setup(item_c.sy, item_c.ey, item_c.sx, item_c.ex, s_yh, s_h, 1'b0);
		su[LANE_EV] = lane_setup(item_c.sx, item_c.ex, item_c.sy, item_c.ey, e_xv, e_v, 1'b1);
		su[LANE_EH] = lane_setup(item_c.sy, item_c.ey, item_c.sx, item_c.ex, e_yh, e_h, 1'b0);
	end

	logic   vld_s1, vld_s2, vld_s3;
	logic   vld_sd [DIV_STAGES];
	item_t  item_s1, item_s2;
	item_t  item_sd [DIV_STAGES];
	setup_t su_s1 [LANES];
	lane_t  lane_s2 [LANES];
	lane_t  lane_sd [DIV_STAGES][LANES];
	prod_t  prod_s2 [LANES];
	mag_t   den_s2 [LANES];
	mag_t   quo [LANES];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) vld_sd[k] <= 1'b0;
		end else if (en) begin
			vld_s1 <= seg.valid;
			vld_s2 <= vld_s1;
			vld_sd[0] <= vld_s2;
			for (int k = 1; k < DIV_STAGES; k++) vld_sd[k] <= vld_sd[k-1];
			vld_s3 <= vld_sd[DIV_STAGES-1];
		end
	end

	// stage 1 and 2 payload, multiply in stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_c;
			item_s2 <= item_s1;
			for (int l = 0; l < LANES; l++) begin
				su_s1[l]   <= su[l];
				lane_s2[l] <= su_s1[l].side;
				prod_s2[l] <= prod_t'(su_s1[l].dv) * prod_t'(su_s1[l].num);
				den_s2[l]  <= su_s1[l].den;
			end
		end
	end

	// side data follows the divider
	always_ff @(posedge clk) begin
		if (en) begin
			item_sd[0] <= item_s2;
			lane_sd[0] <= lane_s2;
			for (int k = 1; k < DIV_STAGES; k++) begin
				item_sd[k] <= item_sd[k-1];
				lane_sd[k] <= lane_sd[k-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_div
		lswc_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (prod_s2[l]),
			.divisor  (den_s2[l]),
			.quotient (quo[l])
		);
	end

	// final: crossing point, window test, pick first hit
	lane_t  lf [LANES];
	ext_t   val [LANES];
	ext_t   px [LANES];
	ext_t   py [LANES];
	logic   hit [LANES];
	item_t  itf;
	logic   hs, he;
	coord_t ax, ay, bx, by;

	always_comb begin
		itf = item_sd[DIV_STAGES-1];
		for (int l = 0; l < LANES; l++) begin
			lf[l]  = lane_sd[DIV_STAGES-1][l];
			val[l] = lf[l].neg ? ext_t'(lf[l].base) - ext_t'(quo[l]) :
				ext_t'(lf[l].base) + ext_t'(quo[l]);
			px[l]  = lf[l].vert ? ext_t'(lf[l].edge_pos) : val[l];
			py[l]  = lf[l].vert ? val[l] : ext_t'(lf[l].edge_pos);
			hit[l] = lf[l].ok && px[l] >= ext_t'(win_q.left) && px[l] <= ext_t'(win_q.right)
				&& py[l] >= ext_t'(win_q.bottom) && py[l] <= ext_t'(win_q.top);
		end
		hs = 1'b1;
		ax = itf.sx;
		ay = itf.sy;
		priority if (itf.rs == RGN_INSIDE) begin
			hs = 1'b1;
		end else if (hit[LANE_SV]) begin
			ax = px[LANE_SV][COORD_BITS-1:0];
			ay = py[LANE_SV][COORD_BITS-1:0];
		end else if (hit[LANE_SH]) begin
			ax = px[LANE_SH][COORD_BITS-1:0];
			ay = py[LANE_SH][COORD_BITS-1:0];
		end else begin
			hs = 1'b0;
		end
		he = 1'b1;
		bx = itf.ex;
		by = itf.ey;
		priority if (itf.re == RGN_INSIDE) begin
			he = 1'b1;
		end else if (hit[LANE_EV]) begin
			bx = px[LANE_EV][COORD_BITS-1:0];
			by = py[LANE_EV][COORD_BITS-1:0];
		end else if (hit[LANE_EH]) begin
			bx = px[LANE_EH][COORD_BITS-1:0];
			by = py[LANE_EH][COORD_BITS-1:0];
		end else begin
			he = 1'b0;
		end
	end

	logic    vis_s3;
	coord_t  ax_s3, ay_s3, bx_s3, by_s3;
	region_t rs_s3, re_s3;

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3 <= hs && he;
			ax_s3  <= (hs && he) ? ax : '0;
			ay_s3  <= (hs && he) ? ay : '0;
			bx_s3  <= (hs && he) ? bx : '0;
			by_s3  <= (hs && he) ? by : '0;
			rs_s3  <= itf.rs;
			re_s3  <= itf.re;
		end
	end

	assign clip.valid        = vld_s3;
	assign clip.visible      = vis_s3;
	assign clip.clip_start_x = ax_s3;
	assign clip.clip_start_y = ay_s3;
	assign clip.clip_end_x   = bx_s3;
	assign clip.clip_end_y   = by_s3;
	assign clip.start_region = rs_s3;
	assign clip.end_region   = re_s3;

	// hidden segments carry zero coordinates
	a_invis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !vis_s3 |-> ax_s3 == '0 && ay_s3 == '0 && bx_s3 == '0 && by_s3 == '0)
		else $error("invisible result with nonzero coordinates");

	// a stalled first stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en |=> vld_s1 && $stable(item_s1))
		else $error("stage 1 lost its item during a stall");

	// divider tail moves into the output register when enabled
	a_tail_move: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_sd[DIV_STAGES-1] |=> vld_s3)
		else $error("item dropped leaving the divider");
endmodule
